// File: hw/rtl/rwta_pkg.sv
package rwta_pkg;

	localparam logic [1:0] TEX_EAST  = 2'd0;
	localparam logic [1:0] TEX_WEST  = 2'd1;
	localparam logic [1:0] TEX_SOUTH = 2'd2;
	localparam logic [1:0] TEX_NORTH = 2'd3;

	localparam logic [1:0] REG_POS_X  = 2'd0;
	localparam logic [1:0] REG_POS_Y  = 2'd1;
	localparam logic [1:0] REG_TEX_W  = 2'd2;
	localparam logic [1:0] REG_TEX_H  = 2'd3;

	localparam int TEX_MAX = 1024;

	// classified request handed from front to back through the queue
	typedef struct packed {
		logic [1:0]  choice;
		logic        mirror;
		logic [27:0] frac;
		logic        row_zero;
		logic        neg;
		logic [29:0] mag;
		logic [15:0] lh;
		logic [11:0] scol;
		logic [11:0] srow;
	} rwta_item_t;

	function automatic logic [10:0] eff_size(input logic [10:0] v);
		logic [10:0] r;
		begin
			r = v;
			if (v == 11'd0)
				r = 11'd1;
			else if (v > 11'(TEX_MAX))
				r = 11'(TEX_MAX);
			return r;
		end
	endfunction

endpackage

// File: hw/rtl/rwta_front.sv
module rwta_front
	import rwta_pkg::*;
#(
	parameter int SCREEN_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               hit_side,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic [23:0]        wall_distance,
	input  logic [15:0]        line_height,
	input  logic [11:0]        row,
	input  logic [11:0]        column,
	input  logic [23:0]        pos_x_q,
	input  logic [23:0]        pos_y_q,
	input  logic               q_full,
	output logic               q_push,
	output rwta_item_t         q_data
);

	logic              v_s1;
	logic [1:0]        choice_s1;
	logic              mirror_s1;
	logic [27:0]       pos_s1;
	logic signed [39:0] prod_s1;
	logic              lhz_s1;
	logic signed [30:0] d_s1;
	logic [15:0]       lh_s1;
	logic [11:0]       scol_s1, srow_s1;
	logic              adv;
	logic [1:0]        choice;
	logic              mirror;
	logic [23:0]       pos;
	logic signed [15:0] dir;
	logic signed [30:0] d;
	logic [27:0]       frac;

	assign adv = !v_s1 || !q_full;
	assign in_stall = !adv;

	// classify texture and select axis
	always_comb begin
		if (!hit_side && dir_x > 0)
			choice = TEX_EAST;
		else if (!hit_side && dir_x < 0)
			choice = TEX_WEST;
		else if (hit_side && dir_y > 0)
			choice = TEX_SOUTH;
		else
			choice = TEX_NORTH;
		mirror = (!hit_side && dir_x > 0) || (hit_side && dir_y < 0);
		pos = hit_side ? pos_x_q : pos_y_q;
		dir = hit_side ? dir_x : dir_y;
		d = 31'(signed'({1'b0, row}) * 256) - 31'(SCREEN_HEIGHT * 128)
			+ 31'(signed'({1'b0, line_height}) * 128);
	end

	// stage 1: multiply distance by direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			choice_s1 <= choice;
			mirror_s1 <= mirror;
			pos_s1    <= {pos[13:0], 14'd0};
			prod_s1   <= signed'({1'b0, wall_distance}) * dir;
			lhz_s1    <= (line_height == 16'd0);
			d_s1      <= d;
			lh_s1     <= line_height;
			scol_s1   <= column;
			srow_s1   <= row;
		end
	end

	// hit fraction and sign split of row numerator
	assign frac = pos_s1 + prod_s1[27:0];
	assign q_push = v_s1 && !q_full;
	always_comb begin
		q_data.choice   = choice_s1;
		q_data.mirror   = mirror_s1;
		q_data.frac     = frac;
		q_data.row_zero = lhz_s1;
		q_data.neg      = d_s1[30];
		q_data.mag      = d_s1[30] ? 30'(-d_s1) : d_s1[29:0];
		q_data.lh       = lh_s1;
		q_data.scol     = scol_s1;
		q_data.srow     = srow_s1;
	end

endmodule

// File: hw/rtl/rwta_fifo.sv
module rwta_fifo
	import rwta_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rwta_item_t wdata,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output rwta_item_t rdata
);

	localparam int AW = $clog2(DEPTH);

	rwta_item_t        mem_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !not_empty |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("fill count slip");

endmodule

// File: hw/rtl/rwta_divider.sv
module rwta_divider #(
	parameter int NW = 41,
	parameter int DW = 16,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_v,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] out_tag
);

	// one quotient bit per stage, restoring
	logic [NW-1:0] n_q  [NW+1];
	logic [DW:0]   r_q  [NW+1];
	logic [DW-1:0] d_q  [NW+1];
	logic [TW-1:0] t_q  [NW+1];
	logic          v_q  [NW+1];

	always_comb begin
		n_q[0] = num;
		r_q[0] = '0;
		d_q[0] = den;
		t_q[0] = tag;
		v_q[0] = in_v;
	end

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW+1:0] sh;
		logic [DW+1:0] df;
		logic [NW-1:0] n_sh;
		logic [DW:0]   r_nx;
		assign sh = {r_q[i], n_q[i][NW-1]};
		assign df = sh - {2'b0, d_q[i]};
		assign n_sh = {n_q[i][NW-2:0], !df[DW+1]};
		assign r_nx = df[DW+1] ? sh[DW:0] : df[DW:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_q[i+1] <= 1'b0;
			else if (en)
				v_q[i+1] <= v_q[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i+1] <= n_sh;
				r_q[i+1] <= r_nx;
				d_q[i+1] <= d_q[i];
				t_q[i+1] <= t_q[i];
			end
		end
	end

	assign out_v   = v_q[NW];
	assign quo     = n_q[NW];
	assign out_tag = t_q[NW];

endmodule

// File: hw/rtl/rwta_back.sv
module rwta_back
	import rwta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  rwta_item_t  q_data,
	output logic        q_pop,
	input  logic [10:0] w_eff,
	input  logic [10:0] h_eff,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  texture_choice,
	output logic [9:0]  texel_column,
	output logic [9:0]  texel_row,
	output logic [19:0] texel_index,
	output logic [11:0] screen_column,
	output logic [11:0] screen_row
);

	localparam int NW = 41;
	localparam int TW = 2 + 10 + 1 + 1 + 11 + 24;
	localparam int RW = 2 + 10 + 10 + 20 + 24;

	logic              en;
	logic              v_b1;
	logic [40:0]       num_b1;
	logic [15:0]       lh_b1;
	logic [TW-1:0]     tag_b1, tag_dv;
	logic              dv_v;
	logic [40:0]       quo;
	logic [10:0]       tx_full;
	logic [9:0]        tx;
	logic [37:0]       fw;
	logic              v_b2;
	logic [TW-1:0]     tag_b2;
	logic [40:0]       quo_b2;
	logic [9:0]        ty_b3, tx_b3;
	logic [1:0]        ch_b3;
	logic [23:0]       sc_b3;
	logic              v_b3;
	logic [32:0]       t;
	logic [9:0]        ty;
	logic              fifo_full, fifo_ne;
	logic              pop_o, push_o;
	logic [19:0]       idx;
	logic [RW-1:0]     res_in, res_out;

	// whole back pipe advances while the result queue has room
	assign en = !fifo_full;
	assign q_pop = q_valid && en;

	// stage b1: column scale and row numerator times height
	assign fw = 38'(q_data.frac) * 38'(w_eff);
	assign tx_full = 11'(fw >> 28);
	assign tx = q_data.mirror ? 10'(w_eff - 11'd1 - tx_full) : tx_full[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_b1 <= 1'b0;
		else if (en)
			v_b1 <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_b1 <= 41'(q_data.mag * h_eff);
			lh_b1  <= q_data.row_zero ? 16'd1 : q_data.lh;
			tag_b1 <= {q_data.choice, tx, q_data.row_zero, q_data.neg, h_eff,
				q_data.scol, q_data.srow};
		end
	end

	rwta_divider #(.NW(NW), .DW(16), .TW(TW)) u_div (
		.clk, .arst_n, .en,
		.in_v(v_b1), .num(num_b1), .den(lh_b1), .tag(tag_b1),
		.out_v(dv_v), .quo, .out_tag(tag_dv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_b2 <= 1'b0;
		else if (en)
			v_b2 <= dv_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_b2 <= quo;
			tag_b2 <= tag_dv;
		end
	end

	// stage b3: divide by 256, clamp
	always_comb begin
		t = 33'(quo_b2 >> 8);
		if (tag_b2[36] || tag_b2[35] || t == '0)
			ty = 10'd0;
		else if (t > 33'(tag_b2[34:24]) - 33'd1)
			ty = 10'(tag_b2[34:24] - 11'd1);
		else
			ty = t[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_b3 <= 1'b0;
		else if (en)
			v_b3 <= v_b2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ty_b3 <= ty;
			tx_b3 <= tag_b2[46:37];
			ch_b3 <= tag_b2[48:47];
			sc_b3 <= tag_b2[23:0];
		end
	end

	// texel index multiply then two-entry result queue
	assign idx = 20'(ty_b3 * w_eff) + 20'(tx_b3);
	assign res_in = {ch_b3, tx_b3, ty_b3, idx, sc_b3};
	assign push_o = v_b3 && en;

	rwta_resq #(.DEPTH(2), .W(RW)) u_resq (
		.clk, .arst_n, .push(push_o), .wdata(res_in), .full(fifo_full),
		.pop(pop_o), .not_empty(fifo_ne), .rdata(res_out)
	);

	assign pop_o = fifo_ne && !out_stall;
	assign out_valid = fifo_ne;
	assign texture_choice = res_out[65:64];
	assign texel_column   = res_out[63:54];
	assign texel_row      = res_out[53:44];
	assign texel_index    = res_out[43:24];
	assign screen_column  = res_out[23:12];
	assign screen_row     = res_out[11:0];

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(texel_index)
		&& $stable(texel_row) && $stable(screen_row)))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> texel_row <= 10'(h_eff - 11'd1))
		else $error("texel row beyond texture");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> texel_column <= 10'(w_eff - 11'd1))
		else $error("texel column beyond texture");

endmodule

// File: hw/rtl/rwta_resq.sv
module rwta_resq #(
	parameter int DEPTH = 47,
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	// circular buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

// File: hw/rtl/raycast_wall_texel_address.sv
// raycast wall texel address
// input channel: in_valid / in_stall with one wall pixel per request;
// output channel: out_valid / out_stall with one texel address per request.
// config channel: cfg_valid / cfg_ready, cfg_index 0..3 selects pos x, pos y,
// texture width, texture height; write only while the block is idle.
// throughput: one request per cycle sustained while out_stall stays low.
// path from input accept to result: the front multiply register, the front queue,
// the b1 register, the 41-stage restoring row divider, the b2 register, the b3
// clamp register and the result queue.
// reset: empties all queues, positions 0, texture sizes 64.
// stall on the output: results wait in a two-entry result queue; once it is
// full the back pipe freezes, the front queue fills and in_stall rises.
// nothing is dropped.
module raycast_wall_texel_address
	import rwta_pkg::*;
#(
	parameter int SCREEN_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               hit_side,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic [23:0]        wall_distance,
	input  logic [15:0]        line_height,
	input  logic [11:0]        row,
	input  logic [11:0]        column,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         texture_choice,
	output logic [9:0]         texel_column,
	output logic [9:0]         texel_row,
	output logic [19:0]        texel_index,
	output logic [11:0]        screen_column,
	output logic [11:0]        screen_row,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	logic [23:0] pos_x_q, pos_y_q;
	logic [10:0] tw_q, th_q, w_eff_q, h_eff_q;
	logic        q_full, q_push, q_ne, q_pop;
	rwta_item_t  q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			tw_q    <= 11'd64;
			th_q    <= 11'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POS_X: pos_x_q <= cfg_data;
				REG_POS_Y: pos_y_q <= cfg_data;
				REG_TEX_W: tw_q    <= cfg_data[10:0];
				REG_TEX_H: th_q    <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		w_eff_q <= eff_size(tw_q);
		h_eff_q <= eff_size(th_q);
	end

	rwta_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .hit_side, .dir_x, .dir_y,
		.wall_distance, .line_height, .row, .column, .pos_x_q, .pos_y_q,
		.q_full, .q_push, .q_data(q_wdata)
	);

	rwta_fifo #(.DEPTH(4)) u_fifo (
		.clk, .arst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .not_empty(q_ne), .rdata(q_rdata)
	);

	rwta_back u_back (
		.clk, .arst_n, .q_valid(q_ne), .q_data(q_rdata), .q_pop,
		.w_eff(w_eff_q), .h_eff(h_eff_q), .out_valid, .out_stall,
		.texture_choice, .texel_column, .texel_row, .texel_index,
		.screen_column, .screen_row
	);

endmodule

// File: dv/raycast_wall_texel_address_test.sv
module raycast_wall_texel_address_test;
	import rwta_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN_H = 1024;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [1:0]  choice;
		logic [9:0]  tcol;
		logic [9:0]  trow;
		logic [19:0] tindex;
		logic [11:0] scol;
		logic [11:0] srow;
	} texel_addr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic hit_side = 1'b0;
	logic signed [15:0] dir_x = '0;
	logic signed [15:0] dir_y = '0;
	logic [23:0] wall_distance = '0;
	logic [15:0] line_height = '0;
	logic [11:0] row = '0;
	logic [11:0] column = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] texture_choice;
	logic [9:0] texel_column;
	logic [9:0] texel_row;
	logic [19:0] texel_index;
	logic [11:0] screen_column;
	logic [11:0] screen_row;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// shadow of the block's registers
	logic [23:0] pos_x_q = '0;
	logic [23:0] pos_y_q = '0;
	logic [10:0] tex_w_q = 11'd64;
	logic [10:0] tex_h_q = 11'd64;

	texel_addr_t pending_texels[$];
	int fail_count = 0;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit no_idle = 1'b0;

	raycast_wall_texel_address #(.SCREEN_HEIGHT(SCREEN_H)) dut (.*);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, pending_texels.size());
			$display("raycast_wall_texel_address_test failed");
			$finish;
		end
	end

	// output stall: long hold when asked, else random, never while no_idle is set
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 11);
		end
	end

	function automatic longint clamp_size(logic [10:0] v);
		if (v == 0)
			return 1;
		if (v > 1024)
			return 1024;
		return v;
	endfunction

	// texel address for one wall pixel under the current registers
	function automatic texel_addr_t texel_address(logic side, logic signed [15:0] dx,
			logic signed [15:0] dy, logic [23:0] wall_dist, logic [15:0] lh,
			logic [11:0] y, logic [11:0] col);
		texel_addr_t r;
		longint w, h, pos, dir, hit, frac, tx, ty, d;
		logic mirror;
		w = clamp_size(tex_w_q);
		h = clamp_size(tex_h_q);
		if (!side && dx > 0)
			r.choice = TEX_EAST;
		else if (!side && dx < 0)
			r.choice = TEX_WEST;
		else if (side && dy > 0)
			r.choice = TEX_SOUTH;
		else
			r.choice = TEX_NORTH;
		pos = side ? longint'(pos_x_q) : longint'(pos_y_q);
		dir = side ? longint'(dx) : longint'(dy);
		hit = (pos << 14) + longint'(wall_dist) * dir;
		frac = hit & 64'hFFF_FFFF;
		tx = (frac * w) >>> 28;
		mirror = (!side && dx > 0) || (side && dy < 0);
		if (mirror)
			tx = w - 1 - tx;
		if (lh == 0) begin
			ty = 0;
		end else begin
			d = longint'(y) * 256 - longint'(SCREEN_H) * 128 + longint'(lh) * 128;
			ty = ((d * h) / longint'(lh)) / 256;
			if (ty < 0)
				ty = 0;
			if (ty > h - 1)
				ty = h - 1;
		end
		r.tcol = tx[9:0];
		r.trow = ty[9:0];
		r.tindex = 20'(ty * w + tx);
		r.scol = col;
		r.srow = y;
		return r;
	endfunction

	// result check against the oldest expected address
	always @(posedge clk) begin
		texel_addr_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_texels.size() == 0) begin
				$display("%0t unexpected result: choice %0d col %0d row %0d", $time,
					texture_choice, texel_column, texel_row);
				fail_count++;
			end else begin
				e = pending_texels.pop_front();
				if ({texture_choice, texel_column, texel_row, texel_index, screen_column,
						screen_row} !== {e.choice, e.tcol, e.trow, e.tindex, e.scol, e.srow}) begin
					$display("%0t mismatch: expected choice %0d col %0d row %0d index %0d scol %0d srow %0d",
						$time, e.choice, e.tcol, e.trow, e.tindex, e.scol, e.srow);
					$display("%0t           actual choice %0d col %0d row %0d index %0d scol %0d srow %0d",
						$time, texture_choice, texel_column, texel_row, texel_index,
						screen_column, screen_row);
					fail_count++;
				end
			end
		end
	end

	// send one pixel request, with an occasional random gap first unless no_idle is set
	task automatic send_pixel(logic side, logic signed [15:0] dx, logic signed [15:0] dy,
			logic [23:0] wall_dist, logic [15:0] lh, logic [11:0] y, logic [11:0] col);
		int gap;
		gap = (!no_idle && $urandom_range(99) < 11) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		hit_side <= side;
		dir_x <= dx;
		dir_y <= dy;
		wall_distance <= wall_dist;
		line_height <= lh;
		row <= y;
		column <= col;
		do @(posedge clk); while (in_stall);
		pending_texels.push_back(texel_address(side, dx, dy, wall_dist, lh, y, col));
	endtask

	task automatic send_random_pixel();
		logic signed [15:0] dx, dy;
		logic [23:0] wall_dist;
		logic [15:0] lh;
		logic [11:0] y;
		int k;
		k = $urandom_range(9);
		dx = (k == 0) ? 16'sd0 : (k == 1) ? 16'sh7FFF : (k == 2) ? 16'sh8000 : 16'($urandom);
		k = $urandom_range(9);
		dy = (k == 0) ? 16'sd0 : (k == 1) ? 16'sh7FFF : (k == 2) ? 16'sh8000 : 16'($urandom);
		k = $urandom_range(9);
		wall_dist = (k == 0) ? 24'hFFFFFF : (k < 4) ? 24'($urandom_range(20'hFFFFF))
			: 24'($urandom);
		k = $urandom_range(19);
		lh = (k == 0) ? 16'd0 : (k == 1) ? 16'($urandom) : 16'($urandom_range(2048, 1));
		// mostly rows inside the drawn span of the wall column
		if ($urandom_range(4) == 0)
			y = 12'($urandom);
		else
			y = 12'(SCREEN_H / 2 - int'(lh) / 2 + $urandom_range(int'(lh) + 1));
		send_pixel(1'($urandom_range(1)), dx, dy, wall_dist, lh, y, 12'($urandom));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		wait (pending_texels.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POS_X: pos_x_q = data;
			REG_POS_Y: pos_y_q = data;
			REG_TEX_W: tex_w_q = data[10:0];
			default:   tex_h_q = data[10:0];
		endcase
	endtask

	// extremes, every texture face, zero direction, zero height, clamping
	task automatic test_directed();
		write_reg(REG_POS_X, 24'h123456);
		write_reg(REG_POS_Y, 24'hFEDCBA);
		send_pixel(1'b0, 16'sh4000, 16'sh1234, 24'h0A0000, 16'd512, 12'd512, 12'd0);
		send_pixel(1'b0, -16'sh4000, 16'sh1234, 24'h0A0000, 16'd512, 12'd300, 12'hFFF);
		send_pixel(1'b1, 16'sh0123, 16'sh4000, 24'h0A0000, 16'd512, 12'd700, 12'd1);
		send_pixel(1'b1, 16'sh0123, -16'sh4000, 24'h0A0000, 16'd512, 12'd511, 12'd2);
		send_pixel(1'b0, 16'sd0, 16'sh7FFF, 24'hFFFFFF, 16'd100, 12'd512, 12'd3);
		send_pixel(1'b1, 16'sh8000, 16'sd0, 24'hFFFFFF, 16'd100, 12'd512, 12'd4);
		send_pixel(1'b0, 16'sh7FFF, 16'sh8000, 24'd0, 16'd0, 12'd0, 12'd5);
		send_pixel(1'b1, 16'sh8000, 16'sh7FFF, 24'd1, 16'd0, 12'hFFF, 12'd6);
		send_pixel(1'b0, 16'sh8000, 16'sh8000, 24'hFFFFFF, 16'd100, 12'd0, 12'd7);
		send_pixel(1'b1, 16'sh7FFF, 16'sh8000, 24'hFFFFFF, 16'd10, 12'hFFF, 12'd8);
		send_pixel(1'b0, 16'sd1, -16'sd1, 24'h800000, 16'hFFFF, 12'd0, 12'd9);
		send_pixel(1'b1, -16'sd1, 16'sd1, 24'h7FFFFF, 16'hFFFF, 12'hFFF, 12'd10);
		send_pixel(1'b0, 16'sh2000, 16'sh5555, 24'h555555, 16'd1, 12'd512, 12'd11);
		send_pixel(1'b1, 16'shAAAA, 16'sh2000, 24'hAAAAAA, 16'd1, 12'd511, 12'd12);
		send_pixel(1'b0, -16'sd5, 16'sh3FFF, 24'h004000, 16'd2048, 12'd1023, 12'hAAA);
		send_pixel(1'b1, 16'sh3FFF, -16'sd5, 24'h004000, 16'd2048, 12'd1, 12'h555);
		wait_idle();
	endtask

	// several register settings including the extremes and the out of range sizes
	task automatic test_config_sweep();
		logic [23:0] settings [8][4] = '{
			'{24'd0, 24'd0, 24'd1, 24'd1},
			'{24'hFFFFFF, 24'hFFFFFF, 24'd1024, 24'd1024},
			'{24'd0, 24'hFFFFFF, 24'd0, 24'd0},
			'{24'hFFFFFF, 24'd0, 24'h7FF, 24'h7FF},
			'{24'h0A3D70, 24'h04000, 24'd1025, 24'd3},
			'{24'h155555, 24'h2AAAAA, 24'd5, 24'd1000},
			'{24'h001234, 24'h3FFFFF, 24'd128, 24'd256},
			'{24'h800000, 24'h7FFFFF, 24'd64, 24'd64}};
		for (int s = 0; s < 8; s++) begin
			write_reg(REG_POS_X, settings[s][0]);
			write_reg(REG_POS_Y, settings[s][1]);
			write_reg(REG_TEX_W, settings[s][2]);
			write_reg(REG_TEX_H, settings[s][3]);
			repeat (60) send_random_pixel();
			wait_idle();
		end
	endtask

	// long random stream, part of it with no idling on either side
	task automatic test_random_stream();
		write_reg(REG_POS_X, 24'($urandom));
		write_reg(REG_POS_Y, 24'($urandom));
		write_reg(REG_TEX_W, 24'($urandom_range(1024, 1)));
		write_reg(REG_TEX_H, 24'($urandom_range(1024, 1)));
		repeat (400) send_random_pixel();
		no_idle = 1'b1;
		repeat (200) send_random_pixel();
		no_idle = 1'b0;
		repeat (100) send_random_pixel();
		wait_idle();
	endtask

	// output held off long enough for the block to fill and stall its input
	task automatic test_output_hold();
		write_reg(REG_TEX_W, 24'd1024);
		write_reg(REG_TEX_H, 24'd37);
		hold_cycles = 400;
		repeat (150) send_random_pixel();
		in_valid <= 1'b0;
		wait (hold_cycles == 0);
		wait_idle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random_stream();
		test_output_hold();
		if (fail_count == 0 && pending_texels.size() == 0)
			$display("raycast_wall_texel_address_test passed");
		else
			$display("raycast_wall_texel_address_test failed");
		$finish;
	end

endmodule
